// File: sv/dtq_pkg.sv
// Shared types and constants of the deadline timer queue.
`timescale 1ns / 1ps
package dtq_pkg;

    localparam int ID_W          = 4;
    localparam int TIME_W        = 32;
    localparam int OP_W          = 2;
    localparam int SLOTS_DEFAULT = 16;

    localparam logic [OP_W-1:0] OP_SCHED   = 2'd0;
    localparam logic [OP_W-1:0] OP_UNSCHED = 2'd1;
    localparam logic [OP_W-1:0] OP_POLL    = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP     = 2'd3;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] deadline;
        logic [TIME_W-1:0] start_time;
    } t_entry;

endpackage

// File: sv/deadline_timer_queue.sv
// Deadline-sorted timer queue held in a circular memory, walked by one sequencer.
`timescale 1ns / 1ps
// A request is taken when start is high and busy is low; busy then stays high
// until the request is done, except for a no-op, which leaves busy low. Entries
// live in a single-port-read memory kept as a circular buffer in deadline order,
// so every entry visited takes an address step, then a check of the registered
// read data. A schedule runs a search, a removal shift, an insert search and an
// insert shift; an unschedule runs the search and removal shift; a poll visits
// each expired timer in turn.
// Each expired timer is shown on o_fired_id, o_elapsed and o_last for exactly
// one cycle with o_valid high; the receiver cannot stall, so it must take every
// result as it comes. No clearing pass follows reset: the queue starts empty.
module deadline_timer_queue #(
    parameter int SLOTS = dtq_pkg::SLOTS_DEFAULT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [dtq_pkg::OP_W-1:0]    i_operation,
    input  logic [dtq_pkg::ID_W-1:0]    i_timer_id,
    input  logic [dtq_pkg::TIME_W-1:0]  i_delay,
    input  logic [dtq_pkg::TIME_W-1:0]  i_now,
    output logic                        o_valid,
    output logic [dtq_pkg::ID_W-1:0]    o_fired_id,
    output logic [dtq_pkg::TIME_W-1:0]  o_elapsed,
    output logic                        o_last
);

    localparam int AW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_RM_RD     = 4'd1;
    localparam logic [3:0] S_RM_CHK    = 4'd2;
    localparam logic [3:0] S_SHD_RD    = 4'd3;
    localparam logic [3:0] S_SHD_WR    = 4'd4;
    localparam logic [3:0] S_INS_START = 4'd5;
    localparam logic [3:0] S_INS_RD    = 4'd6;
    localparam logic [3:0] S_INS_CHK   = 4'd7;
    localparam logic [3:0] S_SHU_RD    = 4'd8;
    localparam logic [3:0] S_SHU_WR    = 4'd9;
    localparam logic [3:0] S_POLL_RD   = 4'd10;
    localparam logic [3:0] S_POLL_CHK  = 4'd11;

    // control state
    logic [3:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_idx, n_idx;
    logic          r_pend_v, n_pend_v;
    logic          r_out_valid, n_out_valid;

    // payload
    logic [dtq_pkg::OP_W-1:0]   r_op, n_op;
    logic [dtq_pkg::ID_W-1:0]   r_id, n_id;
    logic [dtq_pkg::TIME_W-1:0] r_dl, n_dl;
    logic [dtq_pkg::TIME_W-1:0] r_now, n_now;
    logic [CW-1:0]              r_pos, n_pos;
    logic [dtq_pkg::ID_W-1:0]   r_pend_id, n_pend_id;
    logic [dtq_pkg::TIME_W-1:0] r_pend_el, n_pend_el;
    logic [dtq_pkg::ID_W-1:0]   r_out_id, n_out_id;
    logic [dtq_pkg::TIME_W-1:0] r_out_el, n_out_el;
    logic                       r_out_last, n_out_last;

    // entry memory
    dtq_pkg::t_entry r_mem [SLOTS];
    dtq_pkg::t_entry r_rd;
    logic            w_we;
    logic [AW-1:0]   w_waddr;
    logic [AW-1:0]   w_raddr;
    dtq_pkg::t_entry w_wdata;
    logic [3:0]      w_after_rm;

    // Map a queue position to a memory slot, wrapping past the end.
    function automatic logic [AW-1:0] f_phys(input logic [AW-1:0] head,
                                             input logic [AW-1:0] pos);
        logic [AW:0] s;
        s = {1'b0, head} + {1'b0, pos};
        if (s >= (AW+1)'(SLOTS)) begin
            s = s - (AW+1)'(SLOTS);
        end
        return s[AW-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd <= r_mem[w_raddr];
    end

    assign w_after_rm = (r_op == dtq_pkg::OP_SCHED) ? S_INS_START : S_IDLE;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_head      = r_head;
        n_idx       = r_idx;
        n_pend_v    = r_pend_v;
        n_out_valid = 1'b0;
        n_op        = r_op;
        n_id        = r_id;
        n_dl        = r_dl;
        n_now       = r_now;
        n_pos       = r_pos;
        n_pend_id   = r_pend_id;
        n_pend_el   = r_pend_el;
        n_out_id    = r_out_id;
        n_out_el    = r_out_el;
        n_out_last  = r_out_last;
        w_we        = 1'b0;
        w_waddr     = r_head;
        w_wdata     = r_rd;
        w_raddr     = r_head;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op  = i_operation;
                    n_id  = i_timer_id;
                    n_dl  = i_now + i_delay;
                    n_now = i_now;
                    n_idx = '0;
                    unique case (i_operation) inside
                        dtq_pkg::OP_SCHED, dtq_pkg::OP_UNSCHED: n_state = S_RM_RD;
                        dtq_pkg::OP_POLL: begin
                            n_state  = S_POLL_RD;
                            n_pend_v = 1'b0;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_RM_RD: begin
                if (r_idx == r_count) begin
                    n_state = w_after_rm;
                end else begin
                    w_raddr = f_phys(r_head, r_idx[AW-1:0]);
                    n_state = S_RM_CHK;
                end
            end
            S_RM_CHK: begin
                if (r_rd.id == r_id) begin
                    n_state = S_SHD_RD;
                end else begin
                    n_idx   = r_idx + CW'(1);
                    n_state = S_RM_RD;
                end
            end
            S_SHD_RD: begin
                // close the gap left by the removed entry
                if (r_idx + CW'(1) == r_count) begin
                    n_count = r_count - CW'(1);
                    n_state = w_after_rm;
                end else begin
                    w_raddr = f_phys(r_head, r_idx[AW-1:0] + AW'(1));
                    n_state = S_SHD_WR;
                end
            end
            S_SHD_WR: begin
                w_we    = 1'b1;
                w_waddr = f_phys(r_head, r_idx[AW-1:0]);
                n_idx   = r_idx + CW'(1);
                n_state = S_SHD_RD;
            end
            S_INS_START: begin
                // drop the request when the queue is full
                if (r_count == CW'(SLOTS)) begin
                    n_state = S_IDLE;
                end else begin
                    n_idx   = '0;
                    n_state = S_INS_RD;
                end
            end
            S_INS_RD: begin
                if (r_idx == r_count) begin
                    n_pos   = r_idx;
                    n_state = S_SHU_RD;
                end else begin
                    w_raddr = f_phys(r_head, r_idx[AW-1:0]);
                    n_state = S_INS_CHK;
                end
            end
            S_INS_CHK: begin
                // equal deadline: new entry goes in front
                if (r_rd.deadline < r_dl) begin
                    n_idx   = r_idx + CW'(1);
                    n_state = S_INS_RD;
                end else begin
                    n_pos   = r_idx;
                    n_idx   = r_count;
                    n_state = S_SHU_RD;
                end
            end
            S_SHU_RD: begin
                if (r_idx == r_pos) begin
                    w_we    = 1'b1;
                    w_waddr = f_phys(r_head, r_pos[AW-1:0]);
                    w_wdata = '{id: r_id, deadline: r_dl, start_time: r_now};
                    n_count = r_count + CW'(1);
                    n_state = S_IDLE;
                end else begin
                    w_raddr = f_phys(r_head, r_idx[AW-1:0] - AW'(1));
                    n_state = S_SHU_WR;
                end
            end
            S_SHU_WR: begin
                w_we    = 1'b1;
                w_waddr = f_phys(r_head, r_idx[AW-1:0]);
                n_idx   = r_idx - CW'(1);
                n_state = S_SHU_RD;
            end
            S_POLL_RD: begin
                if (r_count == '0) begin
                    n_out_valid = r_pend_v;
                    n_out_last  = 1'b1;
                    n_out_id    = r_pend_id;
                    n_out_el    = r_pend_el;
                    n_state     = S_IDLE;
                end else begin
                    w_raddr = r_head;
                    n_state = S_POLL_CHK;
                end
            end
            S_POLL_CHK: begin
                if (r_rd.deadline < r_now) begin
                    // hold one result back until it is known whether it is the last
                    n_out_valid = r_pend_v;
                    n_out_last  = 1'b0;
                    n_out_id    = r_pend_id;
                    n_out_el    = r_pend_el;
                    n_pend_v    = 1'b1;
                    n_pend_id   = r_rd.id;
                    n_pend_el   = r_now - r_rd.start_time;
                    n_head      = f_phys(r_head, AW'(1));
                    n_count     = r_count - CW'(1);
                    n_state     = S_POLL_RD;
                end else begin
                    n_out_valid = r_pend_v;
                    n_out_last  = 1'b1;
                    n_out_id    = r_pend_id;
                    n_out_el    = r_pend_el;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_head      <= '0;
            r_idx       <= '0;
            r_pend_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_head      <= n_head;
            r_idx       <= n_idx;
            r_pend_v    <= n_pend_v;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_id       <= n_id;
        r_dl       <= n_dl;
        r_now      <= n_now;
        r_pos      <= n_pos;
        r_pend_id  <= n_pend_id;
        r_pend_el  <= n_pend_el;
        r_out_id   <= n_out_id;
        r_out_el   <= n_out_el;
        r_out_last <= n_out_last;
    end

    assign busy       = (r_state != S_IDLE);
    assign o_valid    = r_out_valid;
    assign o_fired_id = r_out_id;
    assign o_elapsed  = r_out_el;
    assign o_last     = r_out_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(SLOTS))
        else $error("queue count exceeds slot count");

    a_idle_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && r_state == S_IDLE) |=> $stable(r_count))
        else $error("queue count changed without a request in progress");

    a_result_in_poll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_state == S_POLL_RD || r_state == S_IDLE))
        else $error("result shown outside a poll");

    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |=> !o_valid)
        else $error("result follows the last result of a poll");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_operation != dtq_pkg::OP_NOP) |=> busy)
        else $error("accepted request did not raise busy");

endmodule
